>>> rtl/signed_integer_radix_printer_defines.svh
// assertion macros shared by the radix printer rtl
// no dependencies; included by files that carry concurrent checks
`ifndef SIGNED_INTEGER_RADIX_PRINTER_DEFINES_SVH
`define SIGNED_INTEGER_RADIX_PRINTER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SIRP_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define SIRP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/sirp_pkg.sv
// shared constants and helpers for the signed integer radix printer
// no dependencies
`timescale 1ns / 1ps

package sirp_pkg;

    localparam int MAX_RADIX_DEF = 16;
    localparam int MAX_DIGITS    = 32;
    localparam int VALUE_W       = 32;
    localparam int SYM_W         = 8;
    localparam int NUM_SYMS      = 16;
    localparam int SYM_IDX_W     = 4;
    localparam int RADIX_W       = 5;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 64;
    localparam int CNT_W         = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LO = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_HI = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIX    = 2'd2;

    localparam logic [SYM_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [SYM_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [SYM_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [SYM_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [SYM_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0] CHAR_ALLON = 8'hFF;

    function automatic logic sym_forbidden(input logic [SYM_W-1:0] c);
        return c inside {CHAR_NUL, CHAR_ALLON, CHAR_SPACE, CHAR_PLUS, CHAR_MINUS,
                         [CHAR_TAB:CHAR_CR]};
    endfunction

endpackage

>>> rtl/signed_integer_radix_printer.sv
// sequence: after the number is accepted, each of the radix alphabet symbols is checked, then each
// digit takes a divider start, a 32-step bit-serial divide and a hand-off, then the words are sent
// one number at a time: a new number is taken only in the idle state, so output stalls hold the input
// a rejected alphabet drops the number after the check; no words are emitted
// reset: synchronous active-low, clears the configuration registers and the control state
// depends on sirp_pkg, sirp_divider and signed_integer_radix_printer_defines.svh
`timescale 1ns / 1ps
`include "signed_integer_radix_printer_defines.svh"

module signed_integer_radix_printer #(
    parameter int MAX_RADIX = sirp_pkg::MAX_RADIX_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [sirp_pkg::VALUE_W-1:0]   s_value,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [sirp_pkg::SYM_W-1:0]            m_symbol,
    output logic                                  m_last,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [sirp_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [sirp_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int DIG_W = $clog2(MAX_RADIX);
    localparam int DIV_W = DIG_W + 1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_START = 3'd2;
    localparam logic [2:0] ST_WAIT  = 3'd3;
    localparam logic [2:0] ST_SIGN  = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    logic [sirp_pkg::CFG_DATA_W-1:0] alpha_lo_reg, alpha_hi_reg;
    logic [sirp_pkg::RADIX_W-1:0]    radix_reg;
    logic [2:0]                      state_reg, state_next;
    logic                            neg_reg, neg_next;
    logic [sirp_pkg::VALUE_W-1:0]    mag_reg, mag_next;
    logic [sirp_pkg::SYM_IDX_W-1:0]  ck_idx_reg, ck_idx_next;
    logic [sirp_pkg::CNT_W-1:0]      dig_cnt_reg, dig_cnt_next;
    logic [DIG_W-1:0]                digits_reg [sirp_pkg::MAX_DIGITS];
    logic                            m_valid_reg, m_valid_next;
    logic [sirp_pkg::SYM_W-1:0]      m_symbol_reg, m_symbol_next;
    logic                            m_last_reg, m_last_next;

    logic [sirp_pkg::SYM_W-1:0]      sym_arr [sirp_pkg::NUM_SYMS];
    logic [sirp_pkg::SYM_W-1:0]      ck_sym;
    logic                            dup_hit;
    logic                            radix_bad;
    logic                            out_free;
    logic                            push;
    logic [DIG_W-1:0]                top_digit;
    logic [sirp_pkg::VALUE_W-1:0]    in_raw;

    logic                            div_start;
    logic                            div_busy;
    logic                            div_done;
    logic [sirp_pkg::VALUE_W-1:0]    div_quo;
    logic [DIG_W-1:0]                div_rem;

    sirp_divider #(
        .MAX_RADIX (MAX_RADIX)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (mag_reg),
        .divisor   (radix_reg[DIV_W-1:0]),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // alphabet view and per-symbol checks
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            sym_arr[k]     = alpha_lo_reg[8*k +: 8];
            sym_arr[k + 8] = alpha_hi_reg[8*k +: 8];
        end
        ck_sym  = sym_arr[ck_idx_reg];
        dup_hit = 1'b0;
        for (int j = 0; j < sirp_pkg::NUM_SYMS; j++) begin
            if ((sirp_pkg::RADIX_W'(j) > {1'b0, ck_idx_reg}) &&
                (sirp_pkg::RADIX_W'(j) < radix_reg) && (sym_arr[j] == ck_sym)) begin
                dup_hit = 1'b1;
            end
        end
        radix_bad = (radix_reg < sirp_pkg::RADIX_W'(2)) ||
                    (radix_reg > sirp_pkg::RADIX_W'(MAX_RADIX));
    end

    assign in_raw    = s_value;
    assign out_free  = !m_valid_reg || m_ready;
    assign top_digit = digits_reg[5'(dig_cnt_reg - 1'b1)];

    always_comb begin
        state_next    = state_reg;
        neg_next      = neg_reg;
        mag_next      = mag_reg;
        ck_idx_next   = ck_idx_reg;
        dig_cnt_next  = dig_cnt_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_symbol_next = m_symbol_reg;
        m_last_next   = m_last_reg;
        div_start     = 1'b0;
        push          = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    neg_next     = in_raw[sirp_pkg::VALUE_W-1];
                    mag_next     = in_raw[sirp_pkg::VALUE_W-1] ? ('0 - in_raw) : in_raw;
                    ck_idx_next  = '0;
                    dig_cnt_next = '0;
                    state_next   = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (radix_bad || sirp_pkg::sym_forbidden(ck_sym) || dup_hit) begin
                    state_next = ST_IDLE;
                end else if ({1'b0, ck_idx_reg} == radix_reg - 1'b1) begin
                    state_next = ST_START;
                end else begin
                    ck_idx_next = ck_idx_reg + 1'b1;
                end
            end
            ST_START: begin
                div_start  = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (div_done) begin
                    push         = 1'b1;
                    dig_cnt_next = dig_cnt_reg + 1'b1;
                    mag_next     = div_quo;
                    if (div_quo == '0) begin
                        state_next = neg_reg ? ST_SIGN : ST_EMIT;
                    end else begin
                        state_next = ST_START;
                    end
                end
            end
            ST_SIGN: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_symbol_next = sirp_pkg::CHAR_MINUS;
                    m_last_next   = 1'b0;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_symbol_next = sym_arr[sirp_pkg::SYM_IDX_W'(top_digit)];
                    m_last_next   = (dig_cnt_reg == sirp_pkg::CNT_W'(1));
                    dig_cnt_next  = dig_cnt_reg - 1'b1;
                    if (dig_cnt_reg == sirp_pkg::CNT_W'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_valid_reg  <= 1'b0;
            dig_cnt_reg  <= '0;
            alpha_lo_reg <= '0;
            alpha_hi_reg <= '0;
            radix_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            dig_cnt_reg <= dig_cnt_next;
            if (cfg_valid) begin
                case (cfg_index)
                    sirp_pkg::CFG_ALPHA_LO: begin
                        alpha_lo_reg <= cfg_data;
                    end
                    sirp_pkg::CFG_ALPHA_HI: begin
                        alpha_hi_reg <= cfg_data;
                    end
                    sirp_pkg::CFG_RADIX: begin
                        radix_reg <= cfg_data[sirp_pkg::RADIX_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
        neg_reg      <= neg_next;
        mag_reg      <= mag_next;
        ck_idx_reg   <= ck_idx_next;
        m_symbol_reg <= m_symbol_next;
        m_last_reg   <= m_last_next;
    end

    // digit stack, pushed least significant first
    always_ff @(posedge aclk) begin
        if (push) begin
            digits_reg[dig_cnt_reg[4:0]] <= div_rem;
        end
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_symbol  = m_symbol_reg;
    assign m_last    = m_last_reg;

    `SIRP_ASSERT_SAME(a_emit_has_digit, aclk, aresetn, state_reg == ST_EMIT, dig_cnt_reg != '0, "emit with empty digit stack")
    `SIRP_ASSERT_SAME(a_digit_bound, aclk, aresetn, 1'b1, dig_cnt_reg <= sirp_pkg::CNT_W'(sirp_pkg::MAX_DIGITS), "digit stack overflow")
    `SIRP_ASSERT_SAME(a_wait_div, aclk, aresetn, state_reg == ST_WAIT, div_busy || div_done, "waiting on idle divider")

endmodule

>>> rtl/sirp_divider.sv
// bit-serial restoring divider: 32-bit magnitude by the radix, one bit per cycle
// depends on sirp_pkg and signed_integer_radix_printer_defines.svh
`timescale 1ns / 1ps
`include "signed_integer_radix_printer_defines.svh"

module sirp_divider #(
    parameter int MAX_RADIX = sirp_pkg::MAX_RADIX_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [sirp_pkg::VALUE_W-1:0]        dividend,
    input  logic [$clog2(MAX_RADIX):0]          divisor,
    output logic                                busy,
    output logic                                done,
    output logic [sirp_pkg::VALUE_W-1:0]        quotient,
    output logic [$clog2(MAX_RADIX)-1:0]        remainder
);

    localparam int DIG_W  = $clog2(MAX_RADIX);
    localparam int DIV_W  = DIG_W + 1;
    localparam int STEP_W = $clog2(sirp_pkg::VALUE_W);

    logic [DIV_W-1:0]            rem_reg, rem_next;
    logic [sirp_pkg::VALUE_W-1:0] quo_reg, quo_next;
    logic [STEP_W-1:0]           step_reg, step_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [DIV_W:0]              trial;
    logic [DIV_W:0]              diff;
    logic                        fits;

    always_comb begin
        trial = {rem_reg, quo_reg[sirp_pkg::VALUE_W-1]};
        fits  = trial >= {1'b0, divisor};
        diff  = trial - {1'b0, divisor};

        rem_next  = rem_reg;
        quo_next  = quo_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            step_next = STEP_W'(sirp_pkg::VALUE_W - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            quo_next  = {quo_reg[sirp_pkg::VALUE_W-2:0], fits};
            step_next = step_reg - 1'b1;
            if (step_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        step_reg <= step_next;
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg[DIG_W-1:0];

    `SIRP_ASSERT_SAME(a_no_restart, aclk, aresetn, start, !busy_reg, "divider restarted while busy")
    `SIRP_ASSERT_SAME(a_done_idle, aclk, aresetn, done_reg, !busy_reg, "done while still busy")
    `SIRP_ASSERT_NEXT(a_start_busy, aclk, aresetn, start, busy_reg, "divider did not start")

endmodule

>>> tb/testbench.sv
// self-checking testbench for signed_integer_radix_printer: prints signed numbers in
// directed and random alphabets and checks every emitted character and its last flag
// depends on sirp_pkg and the signed_integer_radix_printer rtl
`timescale 1ns / 1ps

module testbench;
    import sirp_pkg::*;

    localparam int SETTLE_CYCLES = 1300;
    localparam int SINK_HOLD     = 3000;
    localparam int RANDOM_ITEMS  = 280;

    localparam logic [63:0] DEC_LO = 64'h3736_3534_3332_3130;
    localparam logic [63:0] DEC_HI = 64'h0000_0000_0000_3938;
    localparam logic [63:0] HEX_HI = 64'h4645_4443_4241_3938;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             last;
    } text_char_t;

    typedef struct {
        logic [63:0]               lo;
        logic [63:0]               hi;
        logic [RADIX_W-1:0]        rad;
        logic signed [VALUE_W-1:0] value;
        bit                        typed;
        string                     text;
    } known_case_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [VALUE_W-1:0] s_value = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [SYM_W-1:0] m_symbol;
    logic m_last;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic [63:0] alpha_lo = '0;
    logic [63:0] alpha_hi = '0;
    logic [RADIX_W-1:0] radix_cfg = '0;

    text_char_t pending_chars[$];
    known_case_t known_cases[$];
    int mismatch_count = 0;
    int sink_hold_cycles = 0;
    bit steady_feed = 1'b0;
    text_char_t want;

    signed_integer_radix_printer uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_value   (s_value),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_symbol  (m_symbol),
        .m_last    (m_last),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #50_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic bit is_reserved(input logic [SYM_W-1:0] c);
        return c inside {CHAR_NUL, CHAR_ALLON, CHAR_SPACE, CHAR_PLUS, CHAR_MINUS,
                         [CHAR_TAB:CHAR_CR]};
    endfunction

    function automatic logic [SYM_W-1:0] symbol_at(input int idx);
        if (idx < 8) begin
            return alpha_lo[8 * idx +: 8];
        end
        return alpha_hi[8 * (idx - 8) +: 8];
    endfunction

    function automatic bit alphabet_valid();
        if (radix_cfg < 2 || radix_cfg > MAX_RADIX_DEF) begin
            return 1'b0;
        end
        for (int i = 0; i < radix_cfg; i++) begin
            if (is_reserved(symbol_at(i))) begin
                return 1'b0;
            end
            for (int j = i + 1; j < radix_cfg; j++) begin
                if (symbol_at(j) == symbol_at(i)) begin
                    return 1'b0;
                end
            end
        end
        return 1'b1;
    endfunction

    // most significant digit first, sign ahead of it
    task automatic render_number(input logic signed [VALUE_W-1:0] v);
        logic [31:0] mag;
        int digits[$];
        if (!alphabet_valid()) begin
            return;
        end
        mag = v;
        if (v[31]) begin
            mag = 32'd0 - mag;
            pending_chars.push_back('{CHAR_MINUS, 1'b0});
        end
        do begin
            digits.push_front(int'(mag % radix_cfg));
            mag = mag / radix_cfg;
        end while (mag != 0);
        for (int i = 0; i < digits.size(); i++) begin
            pending_chars.push_back('{symbol_at(digits[i]), i == digits.size() - 1});
        end
    endtask

    function automatic int idle_cycles();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end
        if (roll < 94) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(15, 60);
    endfunction

    function automatic logic [SYM_W-1:0] reserved_byte();
        case ($urandom_range(0, 9))
            0: return CHAR_NUL;
            1: return CHAR_ALLON;
            2: return CHAR_SPACE;
            3: return CHAR_PLUS;
            4: return CHAR_MINUS;
            default: return CHAR_TAB + 8'($urandom_range(0, 4));
        endcase
    endfunction

    function automatic logic signed [VALUE_W-1:0] random_value(input int r);
        logic [31:0] pw;
        logic [31:0] v;
        int k;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            4: return $urandom_range(0, 300);
            5: return -int'($urandom_range(1, 300));
            6: begin
                case ($urandom_range(0, 4))
                    0: return 0;
                    1: return -1;
                    2: return 32'h7FFF_FFFF;
                    3: return 32'h8000_0000;
                    default: return 1;
                endcase
            end
            7: begin
                // digit count boundaries
                if (r < 2) begin
                    r = 10;
                end
                pw = 1;
                k = $urandom_range(1, 31);
                repeat (k) begin
                    if (pw <= 32'hFFFF_FFFF / r) begin
                        pw = pw * r;
                    end
                end
                v = pw - $urandom_range(0, 1);
                return $urandom_range(0, 1) ? v : 32'd0 - v;
            end
            default: begin
                v = $urandom >> $urandom_range(0, 31);
                return $urandom_range(0, 1) ? v : 32'd0 - v;
            end
        endcase
    endfunction

    task automatic pick_alphabet(input int forced, output logic [63:0] lo,
                                 output logic [63:0] hi, output logic [63:0] rdata);
        logic [SYM_W-1:0] syms[16];
        logic [SYM_W-1:0] c;
        int r;
        int p;
        bit clash;
        if (forced != 0) begin
            r = forced;
        end else begin
            case ($urandom_range(0, 11))
                0, 1: r = 2;
                2, 3: r = 16;
                4: r = $urandom_range(0, 1);
                5: r = $urandom_range(17, 31);
                default: r = $urandom_range(3, 15);
            endcase
        end
        for (int k = 0; k < 16; k++) begin
            do begin
                c = 8'($urandom);
                clash = is_reserved(c);
                for (int j = 0; j < k; j++) begin
                    if (syms[j] == c) begin
                        clash = 1'b1;
                    end
                end
            end while (clash);
            syms[k] = c;
        end
        if (forced == 0 && r >= 2 && r <= 16 && $urandom_range(0, 5) == 0) begin
            p = $urandom_range(0, r - 1);
            if ($urandom_range(0, 1)) begin
                syms[p] = reserved_byte();
            end else begin
                syms[p] = syms[(p + $urandom_range(1, r - 1)) % r];
            end
        end
        // junk in slots beyond the radix must be ignored
        for (int k = r; k < 16; k++) begin
            if ($urandom_range(0, 2) == 0) begin
                syms[k] = 8'($urandom);
            end
        end
        for (int k = 0; k < 8; k++) begin
            lo[8 * k +: 8] = syms[k];
            hi[8 * k +: 8] = syms[k + 8];
        end
        rdata = {$urandom, $urandom};
        rdata[RADIX_W-1:0] = r[RADIX_W-1:0];
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic load_alphabet(input logic [63:0] lo, input logic [63:0] hi,
                                 input logic [63:0] rdata);
        write_reg(CFG_ALPHA_LO, lo);
        alpha_lo = lo;
        write_reg(CFG_ALPHA_HI, hi);
        alpha_hi = hi;
        write_reg(CFG_RADIX, rdata);
        radix_cfg = rdata[RADIX_W-1:0];
        cfg_valid <= 1'b0;
    endtask

    task automatic settle_block(input int extra);
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_chars.size() != 0);
        repeat (extra) @(posedge aclk);
    endtask

    task automatic send_number(input logic signed [VALUE_W-1:0] v, input bit typed,
                               input string text);
        int gap;
        gap = steady_feed ? 0 : idle_cycles();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_value <= v;
        do @(posedge aclk); while (!s_ready);
        if (typed) begin
            for (int i = 0; i < text.len(); i++) begin
                pending_chars.push_back('{text[i], i == text.len() - 1});
            end
        end else begin
            render_number(v);
        end
    endtask

    function automatic void add_case(input logic [63:0] lo, input logic [63:0] hi,
                                     input int rad, input logic signed [31:0] value,
                                     input bit typed, input string text);
        known_case_t row;
        row.lo = lo;
        row.hi = hi;
        row.rad = rad[RADIX_W-1:0];
        row.value = value;
        row.typed = typed;
        row.text = text;
        known_cases.push_back(row);
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_chars.size() == 0) begin
                $error("unexpected word: symbol %h last %b", m_symbol, m_last);
                mismatch_count++;
            end else begin
                want = pending_chars.pop_front();
                if (m_symbol !== want.symbol) begin
                    $error("symbol: expected %h, got %h", want.symbol, m_symbol);
                    mismatch_count++;
                end
                if (m_last !== want.last) begin
                    $error("last: expected %b, got %b", want.last, m_last);
                    mismatch_count++;
                end
            end
        end
    end

    // result side
    initial begin
        int run;
        int gap;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (sink_hold_cycles != 0) begin
                m_ready <= 1'b0;
                repeat (sink_hold_cycles) @(posedge aclk);
                sink_hold_cycles = 0;
            end
            m_ready <= 1'b1;
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 6);
            repeat (run) @(posedge aclk);
            gap = idle_cycles();
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    end

    initial begin
        known_case_t row;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] rdata;
        int counted;
        int phase;
        int n;
        bit usable;

        // reset alphabet is empty
        add_case(64'd0, 64'd0, 0, 5, 1'b1, "");
        add_case(DEC_LO, DEC_HI, 10, 0, 1'b1, "0");
        add_case(DEC_LO, DEC_HI, 10, 32'sh7FFF_FFFF, 1'b1, "2147483647");
        add_case(DEC_LO, DEC_HI, 10, 32'sh8000_0000, 1'b1, "-2147483648");
        add_case(DEC_LO, DEC_HI, 10, -1, 1'b1, "-1");
        add_case(DEC_LO, DEC_HI, 10, 10, 1'b1, "10");
        add_case(DEC_LO, 64'hFF2D_2B20_0D09_3938, 10, 123, 1'b1, "123");
        add_case(DEC_LO, DEC_HI, 2, 32'sh8000_0000, 1'b0, "");
        add_case(DEC_LO, DEC_HI, 2, 32'sh7FFF_FFFF, 1'b0, "");
        add_case(DEC_LO, HEX_HI, 16, 32'sh8000_0000, 1'b1, "-80000000");
        add_case(DEC_LO, HEX_HI, 16, 255, 1'b1, "FF");
        add_case(64'h0067_6665_6463_6261, 64'd0, 7, -12345, 1'b0, "");
        add_case(DEC_LO, 64'h0000_0043_4241_3938, 13, 32'sh7FFF_FFFF, 1'b0, "");
        add_case(DEC_LO, DEC_HI, 1, 7, 1'b1, "");
        add_case(DEC_LO, HEX_HI, 17, 7, 1'b1, "");
        add_case(DEC_LO, HEX_HI, 31, 7, 1'b1, "");
        add_case(DEC_LO, 64'h0000_0000_0000_3038, 10, 7, 1'b1, "");
        add_case(64'h3736_3534_3332_2B30, DEC_HI, 10, 7, 1'b1, "");
        add_case(64'h3736_3534_3332_2D30, DEC_HI, 10, 7, 1'b1, "");
        add_case(64'h3736_3534_3332_0930, DEC_HI, 10, 7, 1'b1, "");
        add_case(64'h3736_3534_3332_0D30, DEC_HI, 10, 7, 1'b1, "");
        add_case(64'h3736_3534_3332_2030, DEC_HI, 10, 7, 1'b1, "");
        add_case(DEC_LO, 64'hFF45_4443_4241_3938, 16, 7, 1'b1, "");
        add_case(64'h3736_3534_3300_3130, DEC_HI, 3, 7, 1'b1, "");

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (known_cases[k]) begin
            row = known_cases[k];
            if (row.lo !== alpha_lo || row.hi !== alpha_hi || row.rad !== radix_cfg) begin
                settle_block(SETTLE_CYCLES);
                load_alphabet(row.lo, row.hi, {59'd0, row.rad});
            end
            send_number(row.value, row.typed, row.text);
        end

        counted = 0;
        phase = 0;
        while (counted < RANDOM_ITEMS) begin
            pick_alphabet(phase == 0 ? 2 : (phase == 1 ? 16 : 0), lo, hi, rdata);
            settle_block(SETTLE_CYCLES);
            load_alphabet(lo, hi, rdata);
            usable = alphabet_valid();
            n = usable ? $urandom_range(15, 40) : $urandom_range(2, 5);
            steady_feed = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < n; i++) begin
                if (phase == 0 && i == 3) begin
                    sink_hold_cycles = SINK_HOLD;
                end
                if (phase == 1 && i == 8) begin
                    settle_block(0);
                end
                send_number(random_value(int'(radix_cfg)), 1'b0, "");
                if (usable) begin
                    counted++;
                end
            end
            phase++;
        end

        settle_block(SETTLE_CYCLES);
        if (mismatch_count == 0 && pending_chars.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/sirp_pkg.sv
rtl/sirp_divider.sv
rtl/signed_integer_radix_printer.sv
tb/testbench.sv
